// ----- sv/ble_pkg.sv -----
package ble_pkg;

	// Request codes carried on req_type.
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_READ       = 3'd4;
	localparam logic [2:0] REQ_INSERT     = 3'd5;
	localparam logic [2:0] REQ_REMOVE     = 3'd6;

	// Status codes carried on status.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_UP,
		S_UP_DRAIN,
		S_UP_PUT,
		S_DN,
		S_DN_DRAIN
	} state_t;

endpackage

// ----- sv/bounded_list_engine.sv -----
// Channel   Handshake            Payload
// request   start / busy         req_type, position, data_in
// result    done (one-cycle)     data_out, status, count
//
// Push back, rejected requests and inserts at the tail finish without a shift;
// read and pop back pass through a fetch state. Insert, push front, remove and pop
// front shift the entries that follow the position; the element memory moves one
// entry per cycle.
// Reset clears the element count and the sequencer; memory contents are not
// cleared. The receiver cannot stall: each result is shown for one cycle.
module bounded_list_engine
	import ble_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] data_in,
	output logic               done,
	output logic signed [31:0] data_out,
	output logic [1:0]         status,
	output logic [4:0]         count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	// Element memory, single write port and one registered read port.
	logic [31:0] mem [CAPACITY];
	logic [31:0] rdata_s1;
	logic        rd_valid_s1;
	logic [AW-1:0] rd_addr_s1;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_addr_q, pos_q, last_q;
	logic [31:0]   val_q, cap_q;
	logic [2:0]    op_q;

	logic          res_valid_q;
	logic [31:0]   res_data_q;
	logic [1:0]    res_status_q;

	// Memory port controls and sequencer decisions.
	logic          ren, wen;
	logic [AW-1:0] raddr, waddr;
	logic [31:0]   wdata;
	logic          fin, cnt_inc, cnt_dec;
	logic [31:0]   fin_data;
	logic [1:0]    fin_status;
	logic          load_up, load_dn, cap_en;
	logic [AW-1:0] load_rd_addr, load_pos;

	logic          accept;
	logic [PW-1:0] pos_ext, cnt_ext;
	logic          full, empty;

	assign accept  = start && (state_q == S_IDLE);
	assign pos_ext = PW'(position);
	assign cnt_ext = PW'(cnt_q);
	assign full    = (cnt_ext >= PW'(CAPACITY));
	assign empty   = (cnt_q == '0);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (load_up) begin
					state_d = S_UP;
				end else if (load_dn) begin
					state_d = S_DN;
				end else if (accept && ren) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH:    state_d = S_IDLE;
			S_UP:       state_d = (rd_addr_q == pos_q) ? S_UP_DRAIN : S_UP;
			S_UP_DRAIN: state_d = S_UP_PUT;
			S_UP_PUT:   state_d = S_IDLE;
			S_DN:       state_d = (rd_addr_q == last_q) ? S_DN_DRAIN : S_DN;
			S_DN_DRAIN: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory controls, result values and count updates.
	always_comb begin
		ren          = 1'b0;
		raddr        = rd_addr_q;
		wen          = 1'b0;
		waddr        = pos_q;
		wdata        = val_q;
		fin          = 1'b0;
		fin_data     = '0;
		fin_status   = ST_OK;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		load_up      = 1'b0;
		load_dn      = 1'b0;
		cap_en       = 1'b0;
		load_rd_addr = '0;
		load_pos     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
							if (full) begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end else if (req_type == REQ_INSERT && pos_ext > cnt_ext) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else if (req_type == REQ_PUSH_BACK ||
									(req_type == REQ_INSERT && pos_ext == cnt_ext) ||
									(req_type == REQ_PUSH_FRONT && empty)) begin
								// Placing at the tail needs no shift.
								wen     = 1'b1;
								waddr   = AW'(cnt_q);
								wdata   = data_in;
								fin     = 1'b1;
								cnt_inc = 1'b1;
							end else begin
								load_up      = 1'b1;
								load_rd_addr = AW'(cnt_q - 1'b1);
								load_pos     = (req_type == REQ_INSERT) ? AW'(position) : '0;
							end
						end
						REQ_POP_FRONT, REQ_REMOVE: begin
							if (empty || (req_type == REQ_REMOVE && pos_ext >= cnt_ext)) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else begin
								load_dn      = 1'b1;
								load_pos     = (req_type == REQ_REMOVE) ? AW'(position) : '0;
								load_rd_addr = load_pos;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else begin
								ren   = 1'b1;
								raddr = AW'(cnt_q - 1'b1);
							end
						end
						REQ_READ: begin
							if (pos_ext >= cnt_ext) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else begin
								ren   = 1'b1;
								raddr = AW'(position);
							end
						end
						default: begin
							fin        = 1'b1;
							fin_status = ST_RANGE;
						end
					endcase
				end
			end
			S_FETCH: begin
				fin      = 1'b1;
				fin_data = rdata_s1;
				cnt_dec  = (op_q == REQ_POP_BACK);
			end
			S_UP: begin
				// Reads walk downwards; each returned entry moves one place up.
				ren = 1'b1;
				if (rd_valid_s1) begin
					wen   = 1'b1;
					waddr = rd_addr_s1 + 1'b1;
					wdata = rdata_s1;
				end
			end
			S_UP_DRAIN: begin
				wen   = 1'b1;
				waddr = rd_addr_s1 + 1'b1;
				wdata = rdata_s1;
			end
			S_UP_PUT: begin
				wen     = 1'b1;
				waddr   = pos_q;
				wdata   = val_q;
				fin     = 1'b1;
				cnt_inc = 1'b1;
			end
			S_DN: begin
				// Reads walk upwards; the first entry read is the one removed.
				ren = 1'b1;
				if (rd_valid_s1) begin
					if (rd_addr_s1 == pos_q) begin
						cap_en = 1'b1;
					end else begin
						wen   = 1'b1;
						waddr = rd_addr_s1 - 1'b1;
						wdata = rdata_s1;
					end
				end
			end
			S_DN_DRAIN: begin
				if (rd_addr_s1 != pos_q) begin
					wen   = 1'b1;
					waddr = rd_addr_s1 - 1'b1;
					wdata = rdata_s1;
				end
				fin     = 1'b1;
				cnt_dec = 1'b1;
				if (op_q == REQ_POP_FRONT) begin
					fin_data = (rd_addr_s1 == pos_q) ? rdata_s1 : cap_q;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Element memory.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Read tracking for the shift loops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ren;
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			rd_addr_s1 <= raddr;
		end
		if (cap_en) begin
			cap_q <= rdata_s1;
		end
	end

	// Sequencer state and element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Request payload held for the length of the operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_type;
			val_q  <= data_in;
			pos_q  <= load_pos;
			last_q <= AW'(cnt_q - 1'b1);
		end
		if (load_up || load_dn) begin
			rd_addr_q <= load_rd_addr;
		end else if (state_q == S_UP) begin
			rd_addr_q <= rd_addr_q - 1'b1;
		end else if (state_q == S_DN) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
	end

	// Result strobe and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_data_q   <= fin_data;
			res_status_q <= fin_status;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = res_valid_q;
	assign data_out = res_data_q;
	assign status   = res_status_q;
	assign count    = 5'(cnt_q);

endmodule

// ----- verif/bounded_list_checker.sv -----
`timescale 1ns / 1ps

module bounded_list_checker
	import ble_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] data_in,
	input  logic               done,
	input  logic signed [31:0] data_out,
	input  logic [1:0]         status,
	input  logic [4:0]         count,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         st;
		logic [4:0]         cnt;
	} list_result_t;

	// Shadow copy of the list contents and its length.
	logic signed [31:0] shadow_list [CAPACITY];
	int                 shadow_len;
	list_result_t       awaited_results [$];
	int                 errors;

	// Applies one request to the shadow list and returns the result it should produce.
	function automatic list_result_t list_apply(input logic [2:0] op, input logic [4:0] pos,
			input logic signed [31:0] val);
		list_result_t r;
		int           k;
		r.value = '0;
		r.st    = ST_OK;
		case (op)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (shadow_len >= CAPACITY) begin
					r.st = ST_FULL;
				end else if (op == REQ_PUSH_FRONT) begin
					for (k = shadow_len; k > 0; k--)
						shadow_list[k] = shadow_list[k - 1];
					shadow_list[0] = val;
					shadow_len++;
				end else begin
					shadow_list[shadow_len] = val;
					shadow_len++;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_len == 0) begin
					r.st = ST_RANGE;
				end else begin
					r.value = shadow_list[0];
					for (k = 0; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k + 1];
					shadow_len--;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_len == 0) begin
					r.st = ST_RANGE;
				end else begin
					shadow_len--;
					r.value = shadow_list[shadow_len];
				end
			end
			REQ_READ: begin
				if (int'(pos) >= shadow_len)
					r.st = ST_RANGE;
				else
					r.value = shadow_list[pos];
			end
			REQ_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.st = ST_FULL;
				end else if (int'(pos) > shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (k = shadow_len; k > int'(pos); k--)
						shadow_list[k] = shadow_list[k - 1];
					shadow_list[pos] = val;
					shadow_len++;
				end
			end
			REQ_REMOVE: begin
				if (int'(pos) >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					for (k = int'(pos); k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k + 1];
					shadow_len--;
				end
			end
			default: begin
				// The spare request code is refused and leaves the list alone.
				r.st = ST_RANGE;
			end
		endcase
		r.cnt = shadow_len[4:0];
		return r;
	endfunction

	// Compares each result strobe with the oldest expectation, then records new requests.
	always @(posedge clk or negedge arst_n) begin
		list_result_t exp_r;
		if (!arst_n) begin
			shadow_len = 0;
			awaited_results.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none expected: data_out %0d status %0d count %0d",
						$time, data_out, status, count);
					errors++;
				end else begin
					exp_r = awaited_results[0];
					awaited_results.delete(0);
					if (data_out !== exp_r.value) begin
						$display("%0t: data_out expected %0d got %0d", $time, exp_r.value, data_out);
						errors++;
					end
					if (status !== exp_r.st) begin
						$display("%0t: status expected %0d got %0d", $time, exp_r.st, status);
						errors++;
					end
					if (count !== exp_r.cnt) begin
						$display("%0t: count expected %0d got %0d", $time, exp_r.cnt, count);
						errors++;
					end
				end
			end
			if (start && !busy)
				awaited_results.insert(awaited_results.size(),
					list_apply(req_type, position, data_in));
			fail_count <= errors;
			pending <= awaited_results.size();
		end
	end

endmodule

// ----- verif/bounded_list_engine_tb.sv -----
`timescale 1ns / 1ps

module bounded_list_engine_tb
	import ble_pkg::*;
();

	localparam logic [2:0] REQ_UNUSED   = 3'd7;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         PHASE_ITEMS  = 250;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic [2:0]         req_type = REQ_PUSH_BACK;
	logic [4:0]         position = '0;
	logic signed [31:0] data_in  = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] data_out;
	logic [1:0]         status;
	logic [4:0]         count;
	int                 fail_count;
	int                 pending;
	int                 cycle_count = 0;
	int                 sender_idle_pct = 0;
	bit                 growing = 1'b1;

	bounded_list_engine #(.CAPACITY(16)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.position (position),
		.data_in  (data_in),
		.done     (done),
		.data_out (data_out),
		.status   (status),
		.count    (count)
	);

	bounded_list_checker #(.CAPACITY(16)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.data_in    (data_in),
		.done       (done),
		.data_out   (data_out),
		.status     (status),
		.count      (count),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Guards against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding", pending);
			$display("** bounded_list_engine: FAILED **");
			$finish;
		end
	end

	// Offers one request and holds it until the block takes it in a transfer.
	task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
			input logic signed [31:0] val);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		req_type <= op;
		position <= pos;
		data_in  <= val;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Values that sit on the edges of the signed range turn up now and then.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Leans towards filling or draining the list, so that both full and empty are reached.
	function automatic logic [2:0] pick_request(input bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return REQ_UNUSED;
		if ((r < 72) == grow) begin
			case ($urandom_range(0, 2))
				0:       return REQ_PUSH_FRONT;
				1:       return REQ_PUSH_BACK;
				default: return REQ_INSERT;
			endcase
		end
		case ($urandom_range(0, 3))
			0:       return REQ_POP_FRONT;
			1:       return REQ_POP_BACK;
			2:       return REQ_READ;
			default: return REQ_REMOVE;
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		logic [4:0] pos;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: refusals on an empty list, extremes, both ends and the middle.
		send_request(REQ_POP_FRONT,  5'd0,  32'sd5);
		send_request(REQ_POP_BACK,   5'd0,  32'sd5);
		send_request(REQ_READ,       5'd0,  32'sd0);
		send_request(REQ_REMOVE,     5'd0,  32'sd0);
		send_request(REQ_INSERT,     5'd1,  32'sd9);
		send_request(REQ_UNUSED,     5'd31, 32'sh7FFF_FFFF);
		send_request(REQ_INSERT,     5'd0,  32'sh7FFF_FFFF);
		send_request(REQ_PUSH_FRONT, 5'd31, 32'sh8000_0000);
		send_request(REQ_PUSH_BACK,  5'd16, -32'sd1);
		send_request(REQ_INSERT,     5'd3,  32'sd0);
		send_request(REQ_INSERT,     5'd2,  32'sd12345);
		send_request(REQ_READ,       5'd0,  32'sd0);
		send_request(REQ_READ,       5'd4,  32'sd0);
		send_request(REQ_READ,       5'd5,  32'sd0);
		send_request(REQ_READ,       5'd16, 32'sd0);
		send_request(REQ_INSERT,     5'd7,  32'sd1);
		send_request(REQ_REMOVE,     5'd5,  32'sd0);
		send_request(REQ_REMOVE,     5'd2,  32'sd0);
		send_request(REQ_POP_FRONT,  5'd0,  32'sd0);
		send_request(REQ_POP_BACK,   5'd0,  32'sd0);

		// Random requests in phases of differing sender idling.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1:       sender_idle_pct = 83;
				3:       sender_idle_pct = 26;
				default: sender_idle_pct = 0;
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 59) == 0)
					growing = ~growing;
				if ($urandom_range(0, 99) < 85)
					pos = 5'($urandom_range(0, 16));
				else
					pos = 5'($urandom_range(0, 31));
				send_request(pick_request(growing), pos, pick_value());
			end
		end
		start <= 1'b0;

		// Drain the outstanding results, then allow for any late strobe.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("** bounded_list_engine: PASSED **");
		else
			$display("** bounded_list_engine: FAILED **");
		$finish;
	end

endmodule
